FILE: rtl/restricted_deque_macros.svh
// Assertion macros for the restricted deque.
// Each check samples on the rising edge of i_clk of the module that uses it.
`ifndef RESTRICTED_DEQUE_MACROS_SVH
`define RESTRICTED_DEQUE_MACROS_SVH

`ifndef SYNTH

// Check that is switched off while reset is held
`define RDQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that also holds during reset
`define RDQ_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define RDQ_ASSERT(label, prop, msg)
`define RDQ_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

FILE: rtl/rdq_pkg.sv
`default_nettype none

package rdq_pkg;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_INS_REAR  = 2'd0;
    localparam logic [1:0] OP_INS_FRONT = 2'd1;
    localparam logic [1:0] OP_DEL_FRONT = 2'd2;
    localparam logic [1:0] OP_DEL_REAR  = 2'd3;

    // Status codes carried on the output tuser
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNDER  = 2'd1;
    localparam logic [1:0] ST_OVER   = 2'd2;
    localparam logic [1:0] ST_FORBID = 2'd3;

    // Restriction modes
    localparam logic MODE_IN_RESTRICT  = 1'b0;
    localparam logic MODE_OUT_RESTRICT = 1'b1;

    // Register indexes
    localparam logic REG_RESTRICT_MODE = 1'b0;

    // Field widths fixed by the interface
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OCC_W = 5;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic ins_front;
        logic del_front;
        logic ins_rear;
        logic del_rear;
    } t_cell_ctl;

endpackage

`default_nettype wire

FILE: rtl/rdq_cell.sv
`default_nettype none

module rdq_cell #(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rdq_pkg::t_cell_ctl    i_ctl,
    input  wire  [DATA_WIDTH-1:0] i_value,
    input  wire  [DATA_WIDTH-1:0] i_left_data,
    input  wire                   i_left_valid,
    input  wire  [DATA_WIDTH-1:0] i_right_data,
    input  wire                   i_right_valid,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_rear_data
);

    import rdq_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  r_valid;
    logic                  n_valid;
    logic                  w_is_rear;
    logic                  w_is_slot;

    // This cell holds the rear word, or is the first free place
    assign w_is_rear = r_valid && !i_right_valid;
    assign w_is_slot = !r_valid && i_left_valid;

    // Front insert shifts rearward, front delete frontward; rear ops alter one cell
    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctl.ins_front) begin
            n_data  = i_left_data;
            n_valid = i_left_valid;
        end else if (i_ctl.del_front) begin
            n_data  = i_right_data;
            n_valid = i_right_valid;
        end else if (i_ctl.ins_rear && w_is_slot) begin
            n_data  = i_value;
            n_valid = 1'b1;
        end else if (i_ctl.del_rear && w_is_rear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_rear_data = w_is_rear ? r_data : '0;

endmodule

`default_nettype wire

FILE: rtl/restricted_deque.sv
// Restricted double-ended queue of signed words, built as a row of cells.
//
// Input stream: s_axis_tuser carries the operation (insert rear, insert
// front, delete front, delete rear), s_axis_tdata the word to insert.
// Output stream: one result per input item; m_axis_tuser carries the
// status, m_axis_tdata the removed word and the occupancy after the item.
// APB port: register 0 selects input-restricted (0) or output-restricted (1)
// use; write it only while the block is idle.
//
// Words sit in cells 0..count-1 with the front in cell 0. A front insert or
// delete shifts every cell by one place in the same cycle; a rear insert or
// delete touches only the cell at the boundary of the valid run.
// The result is registered: it appears in the cycle after the input transfer.
// An item is taken every cycle while the receiver takes each result; the rate
// is set by the single output register, which is refilled in the cycle it is emptied.
// Reset (synchronous, active low) empties the deque at once and selects
// input-restricted use. While the receiver stalls a result, the held result
// blocks further input transfers.
`default_nettype none

`include "restricted_deque_macros.svh"

module restricted_deque #(
    parameter int unsigned DEPTH      = 16,
    parameter int unsigned DATA_WIDTH = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // APB configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // [31:0] value
    input  wire  [1:0]  s_axis_tuser,   // [1:0] operation
    // Output stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] removed_value, [36:32] occupancy
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    import rdq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic                  r_restrict;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [VALUE_W-1:0]    r_out_removed;
    logic [VALUE_W-1:0]    n_out_removed;
    logic [STATUS_W-1:0]   r_out_status;
    logic [STATUS_W-1:0]   n_out_status;
    logic [OCC_W-1:0]      r_out_occ;
    logic [OCC_W-1:0]      n_out_occ;

    logic                  w_accept;
    logic [1:0]            w_op;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_forbid;
    logic                  w_empty;
    logic                  w_full;
    logic [DATA_WIDTH-1:0] w_removed;
    logic [DATA_WIDTH-1:0] w_rear;
    t_cell_ctl             w_ctl;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic [DATA_WIDTH-1:0] w_rear_data [DEPTH];
    logic [DEPTH-1:0]      w_valid;

    // APB register access
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RESTRICT_MODE) ? {31'd0, r_restrict} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restrict <= MODE_IN_RESTRICT;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_RESTRICT_MODE) begin
            r_restrict <= pwdata[0];
        end
    end

    // Input transfer whenever the result register is free or being emptied
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_op          = s_axis_tuser;

    // Keep the low stored bits of the input word
    generate
        if (DATA_WIDTH >= VALUE_W) begin : g_val_wide
            assign w_value = DATA_WIDTH'(s_axis_tdata);
        end else begin : g_val_narrow
            assign w_value = s_axis_tdata[DATA_WIDTH-1:0];
        end
    endgenerate

    assign w_empty  = !w_valid[0];
    assign w_full   = w_valid[DEPTH-1];
    assign w_forbid = (r_restrict == MODE_IN_RESTRICT  && w_op == OP_INS_FRONT)
                   || (r_restrict == MODE_OUT_RESTRICT && w_op == OP_DEL_REAR);

    // Pick the rear word out of the one-hot cell outputs
    always_comb begin
        w_rear = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_rear = w_rear | w_rear_data[i];
        end
    end

    // Decode the operation into a cell command and a status
    always_comb begin
        w_ctl        = '0;
        n_out_status = ST_OK;
        n_count      = r_count;
        w_removed    = '0;
        if (w_forbid) begin
            n_out_status = ST_FORBID;
        end else begin
            case (w_op)
                OP_INS_REAR, OP_INS_FRONT: begin
                    if (w_full) begin
                        n_out_status = ST_OVER;
                    end else begin
                        w_ctl.ins_rear  = (w_op == OP_INS_REAR) && w_accept;
                        w_ctl.ins_front = (w_op == OP_INS_FRONT) && w_accept;
                        n_count         = r_count + 1'b1;
                    end
                end
                OP_DEL_FRONT, OP_DEL_REAR: begin
                    if (w_empty) begin
                        n_out_status = ST_UNDER;
                    end else begin
                        w_ctl.del_front = (w_op == OP_DEL_FRONT) && w_accept;
                        w_ctl.del_rear  = (w_op == OP_DEL_REAR) && w_accept;
                        w_removed       = (w_op == OP_DEL_FRONT) ? w_data[0] : w_rear;
                        n_count         = r_count - 1'b1;
                    end
                end
                default: begin
                    n_out_status = ST_FORBID;
                end
            endcase
        end
    end

    // Sign-extend or trim the removed word to the output field
    generate
        if (DATA_WIDTH >= VALUE_W) begin : g_rem_wide
            assign n_out_removed = w_removed[VALUE_W-1:0];
        end else begin : g_rem_narrow
            assign n_out_removed = {{(VALUE_W - DATA_WIDTH){w_removed[DATA_WIDTH-1]}},
                                    w_removed};
        end
        if (CNT_W >= OCC_W) begin : g_occ_wide
            assign n_out_occ = n_count[OCC_W-1:0];
        end else begin : g_occ_narrow
            assign n_out_occ = OCC_W'(n_count);
        end
    endgenerate

    // Row of cells, front in cell 0
    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left_data;
            logic                  w_left_valid;
            logic [DATA_WIDTH-1:0] w_right_data;
            logic                  w_right_valid;

            if (i == 0) begin : g_first
                assign w_left_data  = w_value;
                assign w_left_valid = 1'b1;
            end else begin : g_inner_l
                assign w_left_data  = w_data[i-1];
                assign w_left_valid = w_valid[i-1];
            end

            if (i == DEPTH - 1) begin : g_last
                assign w_right_data  = '0;
                assign w_right_valid = 1'b0;
            end else begin : g_inner_r
                assign w_right_data  = w_data[i+1];
                assign w_right_valid = w_valid[i+1];
            end

            rdq_cell #(
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_rst_n       (i_rst_n),
                .i_ctl         (w_ctl),
                .i_value       (w_value),
                .i_left_data   (w_left_data),
                .i_left_valid  (w_left_valid),
                .i_right_data  (w_right_data),
                .i_right_valid (w_right_valid),
                .o_data        (w_data[i]),
                .o_valid       (w_valid[i]),
                .o_rear_data   (w_rear_data[i])
            );
        end
    endgenerate

    // Element count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result payload until it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_removed <= n_out_removed;
            r_out_status  <= n_out_status;
            r_out_occ     <= n_out_occ;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out_occ, r_out_removed};
    assign m_axis_tuser  = r_out_status;

    // Valid cells form one run starting at the front
    `RDQ_ASSERT(a_valid_run, ((w_valid & (w_valid + 1'b1)) == '0), "valid cells not contiguous")
    // The count tracks the number of valid cells
    `RDQ_ASSERT(a_count_match, ($countones(w_valid) == r_count), "count differs from valid cells")
    // Every input transfer leaves a result waiting
    `RDQ_ASSERT(a_result_follows, (w_accept |=> m_axis_tvalid), "no result after input transfer")
    // A failed or refused item returns no word
    `RDQ_ASSERT(a_fail_zero, (m_axis_tvalid && r_out_status != ST_OK |-> r_out_removed == '0), "word on failed item")
    // Overflow only reported with every cell in use
    `RDQ_ASSERT(a_over_full, (m_axis_tvalid && r_out_status == ST_OVER |-> r_count == CNT_FULL), "overflow while not full")

endmodule

`default_nettype wire
